>>> hdl/butmr_pkg.sv
package butmr_pkg;

   localparam int CntWidth = 16;
   localparam int DataWidth = 16;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_CONTROL = 3'd0,
      REG_ENABLE  = 3'd1,
      REG_STATUS  = 3'd2,
      REG_EVGEN   = 3'd3,
      REG_COUNTER = 3'd4,
      REG_PRESCALE = 3'd5,
      REG_RELOAD  = 3'd6
   } reg_index_type;

   localparam int CtlCen  = 0;
   localparam int CtlUdis = 1;
   localparam int CtlUrs  = 2;
   localparam int CtlOpm  = 3;
   localparam int CtlArpe = 4;

   localparam int EnIrq = 0;
   localparam int EnDma = 1;

   typedef struct packed {
      logic [1:0]           operation;
      logic [2:0]           reg_index;
      logic [DataWidth-1:0] write_data;
   } request_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 update_irq;
      logic                 dma_request;
      logic                 update_event;
   } result_type;

endpackage

>>> hdl/butmr_step.sv
module butmr_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  butmr_pkg::request_type request,
   output butmr_pkg::result_type  result
);
   import butmr_pkg::*;

   logic [CntWidth-1:0]  count_ff, count_in;
   logic [15:0]          psc_count_ff, psc_count_in;
   logic [15:0]          psc_pre_ff, psc_pre_in;
   logic [15:0]          psc_act_ff, psc_act_in;
   logic [CntWidth-1:0]  arr_pre_ff, arr_pre_in;
   logic [CntWidth-1:0]  arr_act_ff, arr_act_in;
   logic [4:0]           ctl_ff, ctl_in;
   logic [1:0]           en_ff, en_in;
   logic                 flag_ff, flag_in;

   logic                 uev;
   logic                 dma;
   logic                 set_flag;
   logic [DataWidth-1:0] rd;
   logic [DataWidth-1:0] wd;

   always_comb begin
      count_in     = count_ff;
      psc_count_in = psc_count_ff;
      psc_pre_in   = psc_pre_ff;
      psc_act_in   = psc_act_ff;
      arr_pre_in   = arr_pre_ff;
      arr_act_in   = arr_act_ff;
      ctl_in       = ctl_ff;
      en_in        = en_ff;
      flag_in      = flag_ff;
      uev          = 1'b0;
      set_flag     = 1'b0;
      rd           = '0;
      wd           = request.write_data;

      case (op_type'(request.operation))
         OP_TICK: begin
            if (ctl_ff[CtlCen]) begin
               if (psc_count_ff >= psc_act_ff) begin
                  psc_count_in = '0;
                  if (count_ff == arr_act_ff) begin
                     count_in = '0;
                     if (!ctl_ff[CtlUdis]) begin
                        uev      = 1'b1;
                        set_flag = 1'b1;
                     end
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  psc_count_in = psc_count_ff + 1'b1;
               end
            end
         end
         OP_WRITE: begin
            case (reg_index_type'(request.reg_index))
               REG_CONTROL:  ctl_in = {wd[7], wd[3:0]};
               REG_ENABLE:   en_in = {wd[8], wd[0]};
               REG_STATUS: begin
                  if (!wd[0]) begin
                     flag_in = 1'b0;
                  end
               end
               REG_EVGEN: begin
                  if (wd[0]) begin
                     count_in     = '0;
                     psc_count_in = '0;
                     if (!ctl_ff[CtlUdis]) begin
                        uev      = 1'b1;
                        set_flag = !ctl_ff[CtlUrs];
                     end
                  end
               end
               REG_COUNTER:  count_in = CntWidth'(wd);
               REG_PRESCALE: psc_pre_in = wd;
               REG_RELOAD: begin
                  arr_pre_in = CntWidth'(wd);
                  if (!ctl_ff[CtlArpe]) begin
                     arr_act_in = CntWidth'(wd);
                  end
               end
               default: ;
            endcase
         end
         OP_READ: begin
            case (reg_index_type'(request.reg_index))
               REG_CONTROL:  rd = {8'd0, ctl_ff[CtlArpe], 3'd0, ctl_ff[3:0]};
               REG_ENABLE:   rd = {7'd0, en_ff[EnDma], 7'd0, en_ff[EnIrq]};
               REG_STATUS:   rd = {15'd0, flag_ff};
               REG_COUNTER:  rd = DataWidth'(count_ff);
               REG_PRESCALE: rd = psc_pre_ff;
               REG_RELOAD:   rd = DataWidth'(arr_pre_ff);
               default:      rd = '0;
            endcase
         end
         default: ;
      endcase

      // update event: load shadows, one-pulse stop; the flag is set on set_flag
      if (uev) begin
         psc_act_in = psc_pre_ff;
         arr_act_in = arr_pre_ff;
         if (ctl_ff[CtlOpm]) begin
            ctl_in[CtlCen] = 1'b0;
         end
      end
      if (set_flag) begin
         flag_in = 1'b1;
      end
      dma = set_flag & en_ff[EnDma];

      result.read_data    = rd;
      result.update_irq   = flag_in & en_in[EnIrq];
      result.dma_request  = dma;
      result.update_event = uev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         psc_count_ff <= '0;
         psc_pre_ff   <= '0;
         psc_act_ff   <= '0;
         arr_pre_ff   <= CntWidth'(16'hFFFF);
         arr_act_ff   <= CntWidth'(16'hFFFF);
         ctl_ff       <= '0;
         en_ff        <= '0;
         flag_ff      <= 1'b0;
      end else if (fire) begin
         count_ff     <= count_in;
         psc_count_ff <= psc_count_in;
         psc_pre_ff   <= psc_pre_in;
         psc_act_ff   <= psc_act_in;
         arr_pre_ff   <= arr_pre_in;
         arr_act_ff   <= arr_act_in;
         ctl_ff       <= ctl_in;
         en_ff        <= en_in;
         flag_ff      <= flag_in;
      end
   end

endmodule

>>> hdl/basic_update_timer_core.sv
// basic 16-bit up-counting timer with prescaler and auto-reload
//
// request channel (req_valid / req_stall): one request per accepted beat;
// req_operation selects a timer tick, a register write or a register read,
// req_reg_index the register, req_write_data the written value
// response channel (rsp_valid / rsp_stall): exactly one response per request,
// in order, carrying read data, the update interrupt level, the dma pulse
// and the update event pulse
// a request accepted into the request register is stepped into the response
// register, which drives rsp_*
// throughput: one request per cycle while rsp_stall does not hold the response;
// the timer state, the compare and the counter increments are all computed
// combinationally between the request register and the response register
// when rsp_stall is high the response holds and the request register keeps
// one more request, after which req_stall rises
// synchronous reset clears both valid bits, the counters, the control and
// enable bits and the flag; the reload registers reset to all ones
module basic_update_timer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_operation,
   input  logic [2:0]                         req_reg_index,
   input  logic [butmr_pkg::DataWidth-1:0]    req_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [butmr_pkg::DataWidth-1:0]    rsp_read_data,
   output logic                               rsp_update_irq,
   output logic                               rsp_dma_request,
   output logic                               rsp_update_event
);
   import butmr_pkg::*;

   logic        in_valid_ff;
   request_type in_req_ff;
   logic        out_valid_ff;
   result_type  out_res_ff;
   result_type  step_res;
   logic        advance;
   logic        take;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;

   butmr_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .request (in_req_ff),
      .result  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff.operation  <= req_operation;
         in_req_ff.reg_index  <= req_reg_index;
         in_req_ff.write_data <= req_write_data;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_res_ff.read_data;
   assign rsp_update_irq   = out_res_ff.update_irq;
   assign rsp_dma_request  = out_res_ff.dma_request;
   assign rsp_update_event = out_res_ff.update_event;

endmodule

>>> tb/basic_update_timer_core_tb.sv
`timescale 1ns / 1ps

module basic_update_timer_core_tb;
   import butmr_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int TOTAL_REQUESTS = 550;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  idx;
      logic [15:0] wd;
      logic        typed;
      result_type  want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_operation;
   logic [2:0]           req_reg_index;
   logic [DataWidth-1:0] req_write_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [DataWidth-1:0] rsp_read_data;
   logic                 rsp_update_irq;
   logic                 rsp_dma_request;
   logic                 rsp_update_event;

   // timer shadow state
   logic [15:0] cnt;
   logic [15:0] psc_cnt;
   logic [15:0] psc_pre;
   logic [15:0] psc_act;
   logic [15:0] arr_pre;
   logic [15:0] arr_act;
   logic [4:0]  ctl;
   logic [1:0]  irq_dma_en;
   logic        uif;

   result_type    timer_rsp_queue[$];
   stim_row_type  stim_rows[$];
   bit            idling;
   int            sent_count;
   int            checked_count;
   int            event_count;
   int            dma_count;
   int            fail_count;

   basic_update_timer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_update_irq   (rsp_update_irq),
      .rsp_dma_request  (rsp_dma_request),
      .rsp_update_event (rsp_update_event)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #2_000_000;
      $display("basic_update_timer_core: mismatch");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] got,
         input logic [15:0] want);
      fail_count++;
      $display("ERROR response %0d: %s got %h want %h", checked_count, field, got, want);
   endtask

   task automatic load_update(input logic set_flag, output logic dma);
      dma = 1'b0;
      psc_act = psc_pre;
      arr_act = arr_pre;
      if (set_flag) begin
         uif = 1'b1;
         dma = irq_dma_en[EnDma];
      end
      if (ctl[CtlOpm]) ctl[CtlCen] = 1'b0;
   endtask

   task automatic advance_timer(input logic [1:0] op, input logic [2:0] idx,
         input logic [15:0] wd, output result_type res);
      logic uev;
      logic dma;
      uev = 1'b0;
      dma = 1'b0;
      res = '0;
      case (op)
         OP_TICK: begin
            if (ctl[CtlCen]) begin
               if (psc_cnt >= psc_act) begin
                  psc_cnt = '0;
                  if (cnt == arr_act) begin
                     cnt = '0;
                     if (!ctl[CtlUdis]) begin
                        uev = 1'b1;
                        load_update(1'b1, dma);
                     end
                  end else begin
                     cnt = cnt + 16'd1;
                  end
               end else begin
                  psc_cnt = psc_cnt + 16'd1;
               end
            end
         end
         OP_WRITE: begin
            case (idx)
               REG_CONTROL: ctl = {wd[7], wd[3:0]};
               REG_ENABLE: irq_dma_en = {wd[8], wd[0]};
               REG_STATUS: begin
                  if (!wd[0]) uif = 1'b0;
               end
               REG_EVGEN: begin
                  if (wd[0]) begin
                     cnt = '0;
                     psc_cnt = '0;
                     if (!ctl[CtlUdis]) begin
                        uev = 1'b1;
                        load_update(!ctl[CtlUrs], dma);
                     end
                  end
               end
               REG_COUNTER: cnt = wd;
               REG_PRESCALE: psc_pre = wd;
               REG_RELOAD: begin
                  arr_pre = wd;
                  if (!ctl[CtlArpe]) arr_act = wd;
               end
               default: ;
            endcase
         end
         OP_READ: begin
            case (idx)
               REG_CONTROL: res.read_data = {8'd0, ctl[CtlArpe], 3'd0, ctl[3:0]};
               REG_ENABLE: res.read_data = {7'd0, irq_dma_en[EnDma], 7'd0, irq_dma_en[EnIrq]};
               REG_STATUS: res.read_data = {15'd0, uif};
               REG_COUNTER: res.read_data = cnt;
               REG_PRESCALE: res.read_data = psc_pre;
               REG_RELOAD: res.read_data = arr_pre;
               default: res.read_data = '0;
            endcase
         end
         default: ;
      endcase
      res.update_irq = uif & irq_dma_en[EnIrq];
      res.dma_request = dma;
      res.update_event = uev;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic [1:0] op, input logic [2:0] idx,
         input logic [15:0] wd, input logic typed, input result_type want);
      result_type pred;
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_reg_index <= idx;
      req_write_data <= wd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_timer(op, idx, wd, pred);
      timer_rsp_queue.push_back(typed ? want : pred);
      sent_count++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic void add_row(input logic [1:0] op, input logic [2:0] idx,
         input logic [15:0] wd, input logic typed, input result_type want);
      stim_row_type row;
      row.op = op;
      row.idx = idx;
      row.wd = wd;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endfunction

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (timer_rsp_queue.size() == 0) begin
            report_mismatch("unexpected response, read_data", rsp_read_data, 16'h0);
         end else begin
            want = timer_rsp_queue.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_update_irq !== want.update_irq)
               report_mismatch("update_irq", 16'(rsp_update_irq), 16'(want.update_irq));
            if (rsp_dma_request !== want.dma_request)
               report_mismatch("dma_request", 16'(rsp_dma_request), 16'(want.dma_request));
            if (rsp_update_event !== want.update_event)
               report_mismatch("update_event", 16'(rsp_update_event),
                  16'(want.update_event));
            event_count += want.update_event;
            dma_count += want.dma_request;
         end
         checked_count++;
      end
   end

   initial begin
      logic [15:0] psc;
      logic [15:0] arr;
      logic [15:0] data;
      int n;
      int r;
      bit paused;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_TICK;
      req_reg_index <= REG_CONTROL;
      req_write_data <= '0;
      idling = 1'b0;
      paused = 1'b0;
      sent_count = 0;
      checked_count = 0;
      event_count = 0;
      dma_count = 0;
      fail_count = 0;
      cnt = '0;
      psc_cnt = '0;
      psc_pre = '0;
      psc_act = '0;
      arr_pre = 16'hFFFF;
      arr_act = 16'hFFFF;
      ctl = '0;
      irq_dma_en = '0;
      uif = 1'b0;

      add_row(OP_READ, REG_CONTROL, 16'h0000, 1'b1, {16'h0000, 3'b000});
      add_row(OP_READ, REG_RELOAD, 16'h0000, 1'b1, {16'hFFFF, 3'b000});
      add_row(OP_READ, REG_PRESCALE, 16'hFFFF, 1'b1, {16'h0000, 3'b000});
      add_row(OP_READ, REG_STATUS, 16'h0000, 1'b1, {16'h0000, 3'b000});
      add_row(OP_READ, REG_EVGEN, 16'h0000, 1'b1, {16'h0000, 3'b000});
      add_row(OP_READ, REG_UNUSED, 16'h0000, 1'b1, {16'h0000, 3'b000});
      add_row(OP_UNUSED, REG_EVGEN, 16'hFFFF, 1'b1, {16'h0000, 3'b000});
      add_row(OP_WRITE, REG_UNUSED, 16'hFFFF, 1'b1, {16'h0000, 3'b000});
      add_row(OP_WRITE, REG_CONTROL, 16'hFFFF, 1'b1, {16'h0000, 3'b000});
      add_row(OP_READ, REG_CONTROL, 16'h0000, 1'b1, {16'h008F, 3'b000});
      add_row(OP_WRITE, REG_ENABLE, 16'h0101, 1'b0, '0);
      add_row(OP_WRITE, REG_CONTROL, 16'h0001, 1'b0, '0);
      add_row(OP_WRITE, REG_RELOAD, 16'h0001, 1'b0, '0);
      add_row(OP_WRITE, REG_PRESCALE, 16'h0001, 1'b0, '0);
      add_row(OP_TICK, REG_CONTROL, 16'h0000, 1'b0, '0);
      add_row(OP_TICK, REG_CONTROL, 16'h0000, 1'b0, '0);
      add_row(OP_WRITE, REG_STATUS, 16'hFFFF, 1'b0, '0);
      add_row(OP_WRITE, REG_STATUS, 16'h0000, 1'b0, '0);
      // updates disabled, then forced update with overflow-only flag and one-pulse
      add_row(OP_WRITE, REG_CONTROL, 16'h0083, 1'b0, '0);
      add_row(OP_WRITE, REG_EVGEN, 16'h0001, 1'b0, '0);
      add_row(OP_WRITE, REG_CONTROL, 16'h000D, 1'b0, '0);
      add_row(OP_WRITE, REG_EVGEN, 16'hFFFF, 1'b0, '0);
      // counter above reload wraps at its maximum with no update
      add_row(OP_WRITE, REG_COUNTER, 16'hFFFF, 1'b0, '0);
      add_row(OP_WRITE, REG_CONTROL, 16'h0001, 1'b0, '0);
      add_row(OP_TICK, REG_CONTROL, 16'h0000, 1'b0, '0);
      add_row(OP_TICK, REG_CONTROL, 16'h0000, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i])
         send_request(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].wd,
            stim_rows[i].typed, stim_rows[i].want);

      while (sent_count < TOTAL_REQUESTS) begin
         idling = ($urandom_range(0, 3) != 0);
         if (!paused && sent_count >= TOTAL_REQUESTS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (timer_rsp_queue.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(3, 12))
               send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  16'($urandom), 1'b0, '0);
         end else begin
            psc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            send_request(OP_WRITE, REG_PRESCALE, psc, 1'b0, '0);
            send_request(OP_WRITE, REG_RELOAD, arr, 1'b0, '0);
            send_request(OP_WRITE, REG_ENABLE, 16'($urandom), 1'b0, '0);
            data = 16'($urandom);
            data[CtlCen] = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) != 0) data[CtlUdis] = 1'b0;
            if ($urandom_range(0, 1) != 0) data[CtlOpm] = 1'b0;
            send_request(OP_WRITE, REG_CONTROL, data, 1'b0, '0);
            data = 16'($urandom);
            data[0] = ($urandom_range(0, 4) != 0);
            send_request(OP_WRITE, REG_EVGEN, data, 1'b0, '0);
            if ($urandom_range(0, 5) == 0)
               send_request(OP_WRITE, REG_COUNTER, 16'hFFFF - 16'($urandom_range(0, 6)),
                  1'b0, '0);
            n = $urandom_range(4, 40);
            repeat (n) begin
               r = $urandom_range(0, 19);
               case (r)
                  0: send_request(OP_READ, 3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
                  1: send_request(OP_WRITE, REG_STATUS, 16'($urandom), 1'b0, '0);
                  2: send_request(OP_WRITE, REG_EVGEN, 16'($urandom), 1'b0, '0);
                  3: send_request(OP_WRITE, REG_RELOAD, 16'($urandom_range(0, 12)), 1'b0, '0);
                  default: send_request(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom),
                     1'b0, '0);
               endcase
            end
            send_request(OP_READ, REG_STATUS, 16'($urandom), 1'b0, '0);
            send_request(OP_READ, REG_COUNTER, 16'($urandom), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (timer_rsp_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d requests sent, %0d responses checked", sent_count, checked_count);
      $display("run: %0d update events, %0d dma pulses, %0d errors", event_count, dma_count,
         fail_count);
      if (fail_count == 0) begin
         $display("basic_update_timer_core: match");
      end else begin
         $display("basic_update_timer_core: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/butmr_pkg.sv
hdl/butmr_step.sv
hdl/basic_update_timer_core.sv
tb/basic_update_timer_core_tb.sv
